// ----- src/mps_pkg.sv -----
// ----------------------------------------------------------------------------
// mps_pkg: shared types and constants for the motion primitive sequencer
// Holds the action and command codes, register indexes, the sequencer state
// type and the fixed geometry constants of the drive.
// ----------------------------------------------------------------------------
package mps_pkg;

   // fixed drive geometry
   localparam int SERVO_CENTRE_US = 1500;
   localparam int ARC_STEER_US    = 300;
   localparam int ARC_RADIUS_MM   = 500;

   // pi/180 in unsigned Q0.32
   localparam logic [63:0] PI_OVER_180_Q32 = 64'd74961321;
   // radius * 16 (1/16 mm) * pi/180, the arc length scale per degree in Q.32
   localparam logic [63:0] ARC_SCALE_Q32 =
      64'(ARC_RADIUS_MM) * 64'd16 * PI_OVER_180_Q32;

   localparam int ARC_RIGHT_RAW = SERVO_CENTRE_US + ARC_STEER_US;
   localparam int ARC_LEFT_RAW  = SERVO_CENTRE_US - ARC_STEER_US;

   localparam logic [11:0] SERVO_CENTRE_VAL = 12'(SERVO_CENTRE_US);
   localparam logic [11:0] ARC_SERVO_RIGHT  =
      12'((ARC_RIGHT_RAW > 4095) ? 4095 : ARC_RIGHT_RAW);
   localparam logic [11:0] ARC_SERVO_LEFT   =
      12'((ARC_LEFT_RAW < 0) ? 0 : ARC_LEFT_RAW);

   // payload widths
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 56;

   // input actions
   localparam logic [2:0] ACT_TICK     = 3'd0;
   localparam logic [2:0] ACT_STRAIGHT = 3'd1;
   localparam logic [2:0] ACT_ARC      = 3'd2;
   localparam logic [2:0] ACT_STOP     = 3'd3;
   localparam logic [2:0] ACT_CLEAR    = 3'd4;

   // drive commands
   localparam logic [2:0] CMD_NONE         = 3'd0;
   localparam logic [2:0] CMD_ALIGN_COAST  = 3'd1;
   localparam logic [2:0] CMD_LAUNCH_LINE  = 3'd2;
   localparam logic [2:0] CMD_LAUNCH_ARC   = 3'd3;
   localparam logic [2:0] CMD_SET_SPEED    = 3'd4;
   localparam logic [2:0] CMD_HALT_BRAKE   = 3'd5;
   localparam logic [2:0] CMD_COAST        = 3'd6;

   // reported mode codes
   localparam logic [2:0] MODE_CODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_CODE_ALIGN   = 3'd1;
   localparam logic [2:0] MODE_CODE_RUN     = 3'd2;
   localparam logic [2:0] MODE_CODE_BRAKE   = 3'd3;
   localparam logic [2:0] MODE_CODE_DONE    = 3'd4;
   localparam logic [2:0] MODE_CODE_TIMEOUT = 3'd5;

   // register indexes
   localparam logic [2:0] REG_COAST_ALLOW   = 3'd0;
   localparam logic [2:0] REG_APPROACH_WIN  = 3'd1;
   localparam logic [2:0] REG_CRUISE_SPEED  = 3'd2;
   localparam logic [2:0] REG_APPROACH_SPD  = 3'd3;
   localparam logic [2:0] REG_ALIGN_WAIT    = 3'd4;
   localparam logic [2:0] REG_TIMEOUT_LIMIT = 3'd5;
   localparam logic [2:0] REG_BRAKE_SETTLE  = 3'd6;
   localparam logic [2:0] REG_ALIGN_SKIP    = 3'd7;

   typedef enum logic [5:0] {
      MODE_IDLE    = 6'b000001,
      MODE_ALIGN   = 6'b000010,
      MODE_RUN     = 6'b000100,
      MODE_BRAKE   = 6'b001000,
      MODE_DONE    = 6'b010000,
      MODE_TIMEOUT = 6'b100000
   } mode_type;

   // one accepted input word, unpacked
   typedef struct packed {
      logic [2:0]         action;
      logic signed [16:0] distance_mm;
      logic [9:0]         arc_degrees;
      logic               arc_forward;
      logic               arc_right;
      logic [11:0]        servo_now_us;
      logic [21:0]        travelled_q4;
      logic [21:0]        arc_len_q4;
   } item_type;

   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] code;
      code = MODE_CODE_IDLE;
      unique case (m)
         MODE_IDLE:    code = MODE_CODE_IDLE;
         MODE_ALIGN:   code = MODE_CODE_ALIGN;
         MODE_RUN:     code = MODE_CODE_RUN;
         MODE_BRAKE:   code = MODE_CODE_BRAKE;
         MODE_DONE:    code = MODE_CODE_DONE;
         MODE_TIMEOUT: code = MODE_CODE_TIMEOUT;
         default:      code = MODE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

// ----- src/motion_primitive_sequencer.sv -----
// ----------------------------------------------------------------------------
// motion_primitive_sequencer: drive primitive sequencer for a small robot
// Turns straight, arc, stop, clear and tick words into drive commands.
// ----------------------------------------------------------------------------
// Each request word produces exactly one response word. The block takes a
// new word every cycle unless both registers are full and the response is
// stalled. The word is unpacked, and its arc length multiply done, on its
// way into the input register. The sequencer step between the input
// register and the result register writes the response once the result
// register is empty or the response ahead of it is being taken.
// The result register stands between the sequencer and rsp_tready, so the
// request side keeps flowing while one response waits; with both registers
// full and the response stalled, req_tready drops. Configuration writes take
// effect on the following edge and are meant for idle periods only.
// Distances are held in 1/16 mm; remaining_mm is the target less the
// odometry reading, truncated toward zero to whole millimetres.
// ----------------------------------------------------------------------------
module motion_primitive_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [2:0] action
   input  logic [2:0]                         req_tuser,
   // [16:0] distance_mm, [26:17] arc_degrees, [27] arc_forward,
   // [28] arc_right, [40:29] servo_now_us, [62:41] travelled_q4, [63] zero
   input  logic [mps_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [2:0] mode, [3] busy_res, [6:4] command, [18:7] speed_rpm,
   // [30:19] servo_cmd_us, [31] arc_right_out, [50:32] remaining_mm,
   // [55:51] zero
   output logic [mps_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // configuration write port
   input  logic                               csr_we,
   input  logic [2:0]                         csr_addr,
   input  logic [15:0]                        csr_wdata
);
   import mps_pkg::*;

   // configuration registers
   logic [9:0]  coast_allow_ff;
   logic [11:0] approach_win_ff;
   logic [10:0] cruise_speed_ff;
   logic [10:0] approach_spd_ff;
   logic [7:0]  align_wait_ff;
   logic [15:0] timeout_limit_ff;
   logic [7:0]  brake_settle_ff;
   logic [9:0]  align_skip_ff;

   // sequencer state
   mode_type           mode_ff, mode_in;
   logic               arc_kind_ff, arc_kind_in;
   logic               reverse_ff, reverse_in;
   logic               curve_right_ff, curve_right_in;
   logic [11:0]        held_servo_ff, held_servo_in;
   logic signed [11:0] last_speed_ff, last_speed_in;
   logic [21:0]        target_ff, target_in;
   logic [16:0]        move_ticks_ff, move_ticks_in;
   logic [7:0]         brake_count_ff, brake_count_in;
   logic [7:0]         align_count_ff, align_count_in;

   // pipeline registers
   logic                     item_valid_ff, item_valid_in;
   item_type                 item_ff, item_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic        advance;
   logic        req_take;

   // input stage signals
   logic [63:0] arc_prod;

   // step signals
   logic [2:0]         cmd;
   logic signed [11:0] speed_out;
   logic [21:0]        line_len_q4;
   logic [16:0]        line_mag;
   logic [21:0]        new_len_q4;
   logic [21:0]        coast_q4;
   logic [21:0]        new_target;
   logic [11:0]        new_servo;
   logic [11:0]        servo_diff;
   logic               skip_settle;
   logic [8:0]         align_next;
   logic [8:0]         brake_next;
   logic [16:0]        move_next;
   logic signed [22:0] run_left;
   logic signed [11:0] want_speed;
   logic signed [22:0] rem_q4;
   logic signed [22:0] rem_adj;
   logic [18:0]        rem_mm;
   logic               busy;
   logic [11:0]        servo_out;
   logic               right_out;

   // ------------------------------------------------------------------------
   // handshake: advance the input register into the result register whenever
   // the result register is empty or being emptied this cycle
   // ------------------------------------------------------------------------
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // input stage: unpack the word and work out the arc length, rounded half up
   // ------------------------------------------------------------------------
   always_comb begin
      arc_prod               = 64'(req_tdata[26:17]) * ARC_SCALE_Q32;
      item_in.action         = req_tuser;
      item_in.distance_mm    = $signed(req_tdata[16:0]);
      item_in.arc_degrees    = req_tdata[26:17];
      item_in.arc_forward    = req_tdata[27];
      item_in.arc_right      = req_tdata[28];
      item_in.servo_now_us   = req_tdata[40:29];
      item_in.travelled_q4   = req_tdata[62:41];
      item_in.arc_len_q4     = 22'((arc_prod + 64'h8000_0000) >> 32);
      item_valid_in          = req_take ? 1'b1 : (advance ? 1'b0 : item_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      if (req_take) begin
         item_ff <= item_in;
      end
   end

   // ------------------------------------------------------------------------
   // sequencer step on the registered word
   // ------------------------------------------------------------------------
   always_comb begin
      // new move: length, target less coast allowance clamped at zero
      line_mag    = item_ff.distance_mm[16] ? (17'd0 - 17'(item_ff.distance_mm))
                                            : 17'(item_ff.distance_mm);
      line_len_q4 = {1'b0, line_mag, 4'b0000};
      new_len_q4  = (item_ff.action == ACT_ARC) ? item_ff.arc_len_q4 : line_len_q4;
      coast_q4    = {8'd0, coast_allow_ff, 4'b0000};
      new_target  = (new_len_q4 > coast_q4) ? (new_len_q4 - coast_q4) : 22'd0;
      new_servo   = (item_ff.action == ACT_ARC)
                    ? (item_ff.arc_right ? ARC_SERVO_RIGHT : ARC_SERVO_LEFT)
                    : SERVO_CENTRE_VAL;
      servo_diff  = (item_ff.servo_now_us > new_servo)
                    ? (item_ff.servo_now_us - new_servo)
                    : (new_servo - item_ff.servo_now_us);
      skip_settle = (align_skip_ff != 10'd0) && (servo_diff <= {2'b00, align_skip_ff});

      // tick arithmetic
      align_next = {1'b0, align_count_ff} + 9'd1;
      brake_next = {1'b0, brake_count_ff} + 9'd1;
      move_next  = move_ticks_ff[16] ? move_ticks_ff : (move_ticks_ff + 17'd1);
      run_left   = $signed({1'b0, target_ff}) - $signed({1'b0, item_ff.travelled_q4});
      if (run_left <= $signed({7'd0, approach_win_ff, 4'b0000})) begin
         want_speed = reverse_ff ? -$signed({1'b0, approach_spd_ff})
                                 : $signed({1'b0, approach_spd_ff});
      end else begin
         want_speed = reverse_ff ? -$signed({1'b0, cruise_speed_ff})
                                 : $signed({1'b0, cruise_speed_ff});
      end

      // hold everything unless the word says otherwise
      mode_in        = mode_ff;
      arc_kind_in    = arc_kind_ff;
      reverse_in     = reverse_ff;
      curve_right_in = curve_right_ff;
      held_servo_in  = held_servo_ff;
      last_speed_in  = last_speed_ff;
      target_in      = target_ff;
      move_ticks_in  = move_ticks_ff;
      brake_count_in = brake_count_ff;
      align_count_in = align_count_ff;
      cmd            = CMD_NONE;
      speed_out      = 12'sd0;

      unique case (item_ff.action)
         ACT_STRAIGHT, ACT_ARC: begin
            // zero distance or zero angle is dropped
            if ((item_ff.action == ACT_STRAIGHT && item_ff.distance_mm != 17'sd0) ||
                (item_ff.action == ACT_ARC && item_ff.arc_degrees != 10'd0)) begin
               if (item_ff.action == ACT_ARC) begin
                  arc_kind_in    = 1'b1;
                  reverse_in     = !item_ff.arc_forward;
                  curve_right_in = item_ff.arc_right;
               end else begin
                  arc_kind_in    = 1'b0;
                  reverse_in     = item_ff.distance_mm[16];
               end
               held_servo_in  = new_servo;
               target_in      = new_target;
               align_count_in = skip_settle ? align_wait_ff : 8'd0;
               move_ticks_in  = 17'd0;
               mode_in        = MODE_ALIGN;
               cmd            = CMD_ALIGN_COAST;
            end
         end
         ACT_STOP: begin
            last_speed_in = 12'sd0;
            mode_in       = MODE_IDLE;
            cmd           = CMD_HALT_BRAKE;
         end
         ACT_CLEAR: begin
            if (mode_ff == MODE_DONE || mode_ff == MODE_TIMEOUT) begin
               mode_in = MODE_IDLE;
            end
         end
         ACT_TICK: begin
            if (mode_ff == MODE_ALIGN) begin
               if (align_next >= {1'b0, align_wait_ff}) begin
                  move_ticks_in  = 17'd0;
                  brake_count_in = 8'd0;
                  last_speed_in  = reverse_ff ? -$signed({1'b0, cruise_speed_ff})
                                              : $signed({1'b0, cruise_speed_ff});
                  mode_in        = MODE_RUN;
                  cmd            = arc_kind_ff ? CMD_LAUNCH_ARC : CMD_LAUNCH_LINE;
                  speed_out      = last_speed_in;
               end else begin
                  align_count_in = align_next[7:0];
               end
            end else if (mode_ff == MODE_RUN || mode_ff == MODE_BRAKE) begin
               move_ticks_in = move_next;
               // timeout wins over any distance test
               if (move_next > {1'b0, timeout_limit_ff}) begin
                  last_speed_in = 12'sd0;
                  mode_in       = MODE_TIMEOUT;
                  cmd           = CMD_HALT_BRAKE;
               end else if (mode_ff == MODE_RUN) begin
                  if (run_left <= 23'sd0) begin
                     last_speed_in  = 12'sd0;
                     brake_count_in = 8'd0;
                     mode_in        = MODE_BRAKE;
                     cmd            = CMD_HALT_BRAKE;
                  end else if (want_speed != last_speed_ff) begin
                     last_speed_in = want_speed;
                     cmd           = CMD_SET_SPEED;
                     speed_out     = want_speed;
                  end
               end else begin
                  if (brake_next >= {1'b0, brake_settle_ff}) begin
                     mode_in = MODE_DONE;
                     cmd     = CMD_COAST;
                  end else begin
                     brake_count_in = brake_next[7:0];
                  end
               end
            end
         end
         default: begin
            // unknown actions: no effect
         end
      endcase

      // remaining distance after the step, truncated toward zero
      rem_q4  = $signed({1'b0, target_in}) - $signed({1'b0, item_ff.travelled_q4});
      rem_adj = rem_q4[22] ? (rem_q4 + 23'sd15) : rem_q4;
      rem_mm  = rem_adj[22:4];

      busy      = (mode_in == MODE_ALIGN) || (mode_in == MODE_RUN) ||
                  (mode_in == MODE_BRAKE);
      servo_out = (cmd == CMD_ALIGN_COAST || cmd == CMD_LAUNCH_LINE ||
                   cmd == CMD_LAUNCH_ARC) ? held_servo_in : 12'd0;
      right_out = (cmd == CMD_LAUNCH_ARC) ? curve_right_in : 1'b0;

      rsp_data_in = {5'd0, rem_mm, right_out, servo_out, speed_out, cmd, busy,
                     mode_code(mode_in)};
      rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         mode_ff        <= MODE_IDLE;
         arc_kind_ff    <= 1'b0;
         reverse_ff     <= 1'b0;
         curve_right_ff <= 1'b0;
         held_servo_ff  <= SERVO_CENTRE_VAL;
         last_speed_ff  <= 12'sd0;
         target_ff      <= 22'd0;
         move_ticks_ff  <= 17'd0;
         brake_count_ff <= 8'd0;
         align_count_ff <= 8'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff        <= mode_in;
            arc_kind_ff    <= arc_kind_in;
            reverse_ff     <= reverse_in;
            curve_right_ff <= curve_right_in;
            held_servo_ff  <= held_servo_in;
            last_speed_ff  <= last_speed_in;
            target_ff      <= target_in;
            move_ticks_ff  <= move_ticks_in;
            brake_count_ff <= brake_count_in;
            align_count_ff <= align_count_in;
         end
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         coast_allow_ff   <= 10'd15;
         approach_win_ff  <= 12'd150;
         cruise_speed_ff  <= 11'd300;
         approach_spd_ff  <= 11'd100;
         align_wait_ff    <= 8'd30;
         timeout_limit_ff <= 16'd3000;
         brake_settle_ff  <= 8'd20;
         align_skip_ff    <= 10'd10;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_COAST_ALLOW:   coast_allow_ff   <= csr_wdata[9:0];
            REG_APPROACH_WIN:  approach_win_ff  <= csr_wdata[11:0];
            REG_CRUISE_SPEED:  cruise_speed_ff  <= csr_wdata[10:0];
            REG_APPROACH_SPD:  approach_spd_ff  <= csr_wdata[10:0];
            REG_ALIGN_WAIT:    align_wait_ff    <= csr_wdata[7:0];
            REG_TIMEOUT_LIMIT: timeout_limit_ff <= csr_wdata;
            REG_BRAKE_SETTLE:  brake_settle_ff  <= csr_wdata[7:0];
            REG_ALIGN_SKIP:    align_skip_ff    <= csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // a stalled word in the input register is never dropped
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !advance |=> item_valid_ff)
      else $error("input word lost while stalled");

   // every step lands in the result register
   a_step_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("step result not captured");

   // a launch only ever comes out of the align state
   a_launch_from_align: assert property (@(posedge clock) disable iff (reset)
      advance && (cmd == CMD_LAUNCH_LINE || cmd == CMD_LAUNCH_ARC)
      |-> mode_ff == MODE_ALIGN)
      else $error("launch outside align");

   // braking always comes with a zero held speed
   a_brake_speed: assert property (@(posedge clock) disable iff (reset)
      advance && cmd == CMD_HALT_BRAKE |=> last_speed_ff == 12'sd0)
      else $error("speed held after halt");
`endif

endmodule
